// File: src/min_order_buffer_number_queue_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the min order buffer number queue
// Shared immediate-implication and next-cycle forms of concurrent checks.
// ----------------------------------------------------------------------------
`ifndef MIN_ORDER_BUFFER_NUMBER_QUEUE_ASSERT_SVH
`define MIN_ORDER_BUFFER_NUMBER_QUEUE_ASSERT_SVH

// same-cycle implication
`define MOBNQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mobnq check failed");

// next-cycle implication
`define MOBNQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mobnq check failed");

`endif

// File: src/mobnq_pkg.sv
// ----------------------------------------------------------------------------
// mobnq_pkg
// Widths, default depth and command codes of the min order buffer number queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mobnq_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned ValueWidth   = 30;
  localparam int unsigned CountOutWidth = 5;

  localparam logic CmdPush = 1'b0;
  localparam logic CmdPop  = 1'b1;

endpackage

`default_nettype wire

// File: src/min_order_buffer_number_queue.sv
// ----------------------------------------------------------------------------
// min_order_buffer_number_queue
// Bounded table of buffer sequence numbers with push and pop-smallest.
// ----------------------------------------------------------------------------
// Each input beat carries a push or a pop and gives exactly one result beat.
// Entries live in a single-port-read, single-port-write memory, and one
// comparator walks it one entry per cycle. A push on a table that is not full
// writes the value behind the last entry without a scan; a push on a full
// table scans all Depth entries; a pop on a table of n entries scans n entries
// and then closes the gap behind the removed one. The one read port of the
// entry memory sets the pace of these walks. The input stalls while an item
// is at work; a finished result waits in the output register and does not
// hold up the next input beat.
// ----------------------------------------------------------------------------
`default_nettype none

module min_order_buffer_number_queue #(
  parameter int unsigned Depth = mobnq_pkg::DefaultDepth
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               command_i,
  input  wire logic [mobnq_pkg::ValueWidth-1:0]   value_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic                                    popped_valid_o,
  output logic [mobnq_pkg::ValueWidth-1:0]        popped_value_o,
  output logic [mobnq_pkg::CountOutWidth-1:0]     entry_count_o
);
  import mobnq_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StShift,
    StDone
  } state_e;

  typedef logic [ValueWidth-1:0] value_t;

  value_t          mem_q [Depth];
  value_t          rdata_q;
  logic [AW-1:0]   raddr;
  logic            we;
  logic [AW-1:0]   waddr;
  value_t          wdata;

  state_e          state_q, state_d;
  logic            cmd_q, cmd_d;
  value_t          val_q, val_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   n_q, n_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic            chk_vld_q, chk_vld_d;
  logic [AW-1:0]   chk_idx_q, chk_idx_d;
  value_t          best_val_q, best_val_d;
  logic [AW-1:0]   best_pos_q, best_pos_d;
  logic            pend_q, pend_d;
  logic [AW-1:0]   pend_addr_q, pend_addr_d;
  logic            res_valid_q, res_valid_d;
  value_t          res_value_q, res_value_d;
  logic            out_valid_q, out_valid_d;
  logic            pv_q, pv_d;
  value_t          pval_q, pval_d;
  logic [CountOutWidth-1:0] ecnt_q, ecnt_d;

  logic            in_acc;
  logic            issue;
  logic            last_chk;
  logic            slot_free;

  assign in_stall_o     = (state_q != StIdle);
  assign in_acc         = in_valid_i && (state_q == StIdle);
  assign out_valid_o    = out_valid_q;
  assign popped_valid_o = pv_q;
  assign popped_value_o = pval_q;
  assign entry_count_o  = ecnt_q;
  assign slot_free      = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    val_d       = val_q;
    count_d     = count_q;
    n_d         = n_q;
    idx_d       = idx_q;
    chk_vld_d   = 1'b0;
    chk_idx_d   = chk_idx_q;
    best_val_d  = best_val_q;
    best_pos_d  = best_pos_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    res_valid_d = res_valid_q;
    res_value_d = res_value_q;
    out_valid_d = out_valid_q;
    pv_d        = pv_q;
    pval_d      = pval_q;
    ecnt_d      = ecnt_q;
    raddr       = idx_q[AW-1:0];
    we          = 1'b0;
    waddr       = count_q[AW-1:0];
    wdata       = value_i;
    issue       = 1'b0;
    last_chk    = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          cmd_d       = command_i;
          val_d       = value_i;
          res_valid_d = 1'b0;
          res_value_d = '0;
          idx_d       = '0;
          if (command_i == CmdPush && count_q < CW'(Depth)) begin
            we      = 1'b1;
            count_d = count_q + CW'(1);
            state_d = StDone;
          end else if (command_i == CmdPop && count_q == '0) begin
            state_d = StDone;
          end else begin
            n_d     = (command_i == CmdPush) ? CW'(Depth) : count_q;
            state_d = StScan;
          end
        end
      end

      StScan: begin
        issue = (idx_q < n_q);
        raddr = idx_q[AW-1:0];
        if (issue) begin
          chk_vld_d = 1'b1;
          chk_idx_d = idx_q[AW-1:0];
          idx_d     = idx_q + CW'(1);
        end
        if (chk_vld_q) begin
          if (chk_idx_q == '0 || rdata_q < best_val_q) begin
            best_val_d = rdata_q;
            best_pos_d = chk_idx_q;
          end
          last_chk = (CW'(chk_idx_q) == n_q - CW'(1));
        end
        if (last_chk) begin
          chk_vld_d = 1'b0;
          if (cmd_q == CmdPush) begin
            we      = 1'b1;
            waddr   = best_pos_d;
            wdata   = val_q;
            state_d = StDone;
          end else begin
            res_valid_d = 1'b1;
            res_value_d = best_val_d;
            idx_d       = CW'(best_pos_d) + CW'(1);
            state_d     = StShift;
          end
        end
      end

      StShift: begin
        issue = (idx_q < count_q);
        raddr = idx_q[AW-1:0];
        if (issue) begin
          pend_d      = 1'b1;
          pend_addr_d = AW'(idx_q - CW'(1));
          idx_d       = idx_q + CW'(1);
        end
        if (pend_q) begin
          we    = 1'b1;
          waddr = pend_addr_q;
          wdata = rdata_q;
        end
        if (!issue && !pend_q) begin
          count_d = count_q - CW'(1);
          state_d = StDone;
        end
      end

      StDone: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          pv_d        = res_valid_q;
          pval_d      = res_value_q;
          ecnt_d      = CountOutWidth'(count_q);
          state_d     = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      chk_vld_q   <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      chk_vld_q   <= chk_vld_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    val_q       <= val_d;
    n_q         <= n_d;
    idx_q       <= idx_d;
    chk_idx_q   <= chk_idx_d;
    best_val_q  <= best_val_d;
    best_pos_q  <= best_pos_d;
    pend_addr_q <= pend_addr_d;
    res_valid_q <= res_valid_d;
    res_value_q <= res_value_d;
    pv_q        <= pv_d;
    pval_q      <= pval_d;
    ecnt_q      <= ecnt_d;
  end

endmodule

`default_nettype wire

// File: src/mobnq_checker.sv
// ----------------------------------------------------------------------------
// mobnq_checker
// Port-level checks of the min order buffer number queue, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "min_order_buffer_number_queue_assert.svh"

module mobnq_checker #(
  parameter int unsigned Depth = mobnq_pkg::DefaultDepth
) (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               in_valid_i,
  input wire logic                               in_stall_o,
  input wire logic                               command_i,
  input wire logic [mobnq_pkg::ValueWidth-1:0]   value_i,
  input wire logic                               out_valid_o,
  input wire logic                               out_stall_i,
  input wire logic                               popped_valid_o,
  input wire logic [mobnq_pkg::ValueWidth-1:0]   popped_value_o,
  input wire logic [mobnq_pkg::CountOutWidth-1:0] entry_count_o
);
  import mobnq_pkg::*;

  logic in_acc;
  logic push_beat;
  logic push_known;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign push_beat  = in_acc && (command_i == CmdPush);
  assign push_known = (value_i == value_i);

  `MOBNQ_ASSERT_NXT(a_hold_out, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(popped_value_o) && $stable(entry_count_o))
  `MOBNQ_ASSERT_IMP(a_zero_on_invalid, clk_i, rst_ni, out_valid_o && !popped_valid_o, popped_value_o == '0)
  `MOBNQ_ASSERT_IMP(a_count_range, clk_i, rst_ni, out_valid_o, (Depth > 31) || (entry_count_o <= Depth))
  `MOBNQ_ASSERT_NXT(a_busy_after_beat, clk_i, rst_ni, push_beat && push_known, in_stall_o)

endmodule

bind min_order_buffer_number_queue mobnq_checker #(.Depth(Depth)) u_mobnq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .command_i      (command_i),
  .value_i        (value_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .popped_valid_o (popped_valid_o),
  .popped_value_o (popped_value_o),
  .entry_count_o  (entry_count_o)
);

`default_nettype wire
